FILE: rtl/core/byte_register_cpu_core_assert.svh
// ----------------------------------------------------------------------------
// byte_register_cpu_core assertion macros
// Shared property wrappers; all sample on clock and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_REGISTER_CPU_CORE_ASSERT_SVH
`define BYTE_REGISTER_CPU_CORE_ASSERT_SVH

// Same-cycle implication
`define BRC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brc check failed");

// Next-cycle implication
`define BRC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brc check failed");

`endif

FILE: rtl/core/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared constants, opcodes and controller/datapath types of the byte CPU.
// ----------------------------------------------------------------------------
package brc_pkg;

   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int RET_DEPTH = 256;
   localparam int RET_AW    = $clog2(RET_DEPTH);
   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int WORD_W    = 8;
   localparam int PC_W      = 16;
   localparam int DIV_CNT_W = $clog2(WORD_W);

   // Fixed register roles
   localparam logic [REG_IDX_W-1:0] REG_OFFSET = REG_IDX_W'(5);
   localparam logic [REG_IDX_W-1:0] REG_PTR_LO = REG_IDX_W'(6);
   localparam logic [REG_IDX_W-1:0] REG_PTR_HI = REG_IDX_W'(7);

   // Flag bit positions
   localparam int FLAG_EQ = 0;
   localparam int FLAG_GT = 1;

   typedef logic [1:0] action_type;
   localparam action_type ACT_CODE_WR = 2'd0;
   localparam action_type ACT_DATA_WR = 2'd1;
   localparam action_type ACT_EXECUTE = 2'd2;

   typedef logic [7:0] opcode_type;
   localparam opcode_type OP_HALT      = 8'd0;
   localparam opcode_type OP_NOP       = 8'd1;
   localparam opcode_type OP_LOAD_IMM  = 8'd2;
   localparam opcode_type OP_MOVE      = 8'd3;
   localparam opcode_type OP_LOAD      = 8'd4;
   localparam opcode_type OP_STORE     = 8'd5;
   localparam opcode_type OP_STORE_IND = 8'd6;
   localparam opcode_type OP_STORE_PTR = 8'd7;
   localparam opcode_type OP_PUSH      = 8'd8;
   localparam opcode_type OP_POP       = 8'd9;
   localparam opcode_type OP_JUMP      = 8'd10;
   localparam opcode_type OP_CALL      = 8'd11;
   localparam opcode_type OP_RETURN    = 8'd12;
   localparam opcode_type OP_INC       = 8'd13;
   localparam opcode_type OP_DEC       = 8'd14;
   localparam opcode_type OP_ADD       = 8'd15;
   localparam opcode_type OP_SUB       = 8'd16;
   localparam opcode_type OP_MUL       = 8'd17;
   localparam opcode_type OP_DIV       = 8'd18;
   localparam opcode_type OP_AND       = 8'd19;
   localparam opcode_type OP_OR        = 8'd20;
   localparam opcode_type OP_XOR       = 8'd21;
   localparam opcode_type OP_NOT       = 8'd22;
   localparam opcode_type OP_SHL       = 8'd23;
   localparam opcode_type OP_SHR       = 8'd24;
   localparam opcode_type OP_CMP       = 8'd25;
   localparam opcode_type OP_JEQ       = 8'd26;
   localparam opcode_type OP_JNE       = 8'd27;
   localparam opcode_type OP_JGT       = 8'd28;
   localparam opcode_type OP_JLE       = 8'd29;
   localparam opcode_type OP_CODE_LOAD = 8'd30;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH_OP,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_READ_A,
      ST_READ_B,
      ST_EXEC,
      ST_MEM_WAIT,
      ST_PTR_LO,
      ST_PTR_HI,
      ST_PTR_WR,
      ST_RET_LO,
      ST_RET_HI,
      ST_DIV,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      ctl_state_type step;
      logic          accept;
      logic          rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       running;
      logic       divisor_zero;
      logic       div_last;
   } dp_status_type;

   typedef struct packed {
      logic [PC_W-1:0]   program_counter;
      logic              is_running;
      logic [1:0]        flag_bits;
      logic [2:0]        dest_index;
      logic [WORD_W-1:0] dest_value;
      logic              dest_valid;
      logic              divide_fault;
   } result_type;

endpackage

FILE: rtl/core/brc_req_if.sv
// ----------------------------------------------------------------------------
// brc_req_if
// Request channel: valid/ready with action, address and data byte.
// ----------------------------------------------------------------------------
interface brc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, action, address, data, input ready);
   modport sink   (input valid, action, address, data, output ready);
endinterface

FILE: rtl/core/brc_rsp_if.sv
// ----------------------------------------------------------------------------
// brc_rsp_if
// Response channel: valid/ready with machine status after each request.
// ----------------------------------------------------------------------------
interface brc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] program_counter;
   logic        is_running;
   logic [1:0]  flag_bits;
   logic [2:0]  dest_index;
   logic [7:0]  dest_value;
   logic        dest_valid;
   logic        divide_fault;

   modport source (output valid, program_counter, is_running, flag_bits, dest_index,
                   dest_value, dest_valid, divide_fault, input ready);
   modport sink   (input valid, program_counter, is_running, flag_bits, dest_index,
                   dest_value, dest_valid, divide_fault, output ready);
endinterface

FILE: rtl/core/brc_datapath.sv
// ----------------------------------------------------------------------------
// brc_datapath
// Register file, code/data/return memories, ALU, serial divider and the
// response register, all stepped by the controller's command.
// ----------------------------------------------------------------------------
module brc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  brc_pkg::ctl_cmd_type   cmd,
   input  brc_pkg::action_type    req_action,
   input  logic [15:0]            req_address,
   input  logic [7:0]             req_data,
   output brc_pkg::dp_status_type status,
   output brc_pkg::result_type    result
);
   import brc_pkg::*;

   // Architectural state
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic                 run_ff, run_in;
   logic [1:0]           flags_ff, flags_in;
   logic [WORD_W-1:0]    rf_ff [NUM_REGS];
   logic [WORD_W-1:0]    rf_in [NUM_REGS];
   logic [MEM_AW-1:0]    dsp_ff, dsp_in;
   logic [RET_AW-1:0]    rtn_sp_ff, rtn_sp_in;

   // Instruction working registers
   opcode_type           op_ff, op_in;
   logic [WORD_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [WORD_W-1:0]    va_ff, va_in, vb_ff, vb_in;
   logic [MEM_AW-1:0]    ptr_ff, ptr_in;
   logic [WORD_W-1:0]    quo_ff, quo_in, rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REG_IDX_W-1:0] dest_idx_ff, dest_idx_in;
   logic [WORD_W-1:0]    dest_val_ff, dest_val_in;
   logic                 dest_vld_ff, dest_vld_in;
   logic                 fault_ff, fault_in;
   result_type           res_ff, res_in;

   // Memories
   logic [WORD_W-1:0]    code_mem_ff [MEM_DEPTH];
   logic [WORD_W-1:0]    data_mem_ff [MEM_DEPTH];
   logic [WORD_W-1:0]    ret_mem_ff  [RET_DEPTH];
   logic [WORD_W-1:0]    code_q_ff, data_q_ff, ret_q_ff;
   logic [MEM_AW-1:0]    code_addr, data_addr;
   logic [RET_AW-1:0]    ret_addr;
   logic                 code_we, data_we, ret_we;
   logic [WORD_W-1:0]    code_wdata, data_wdata, ret_wdata;

   // Helpers
   logic [MEM_AW-1:0]    hilo, hilo_off, pc_inc;
   logic [REG_IDX_W-1:0] a_idx, b_idx, rd_idx;
   logic [WORD_W-1:0]    rd_val, alu_val;
   logic [2*WORD_W-1:0]  product;
   logic                 rf_we;
   logic [REG_IDX_W-1:0] rf_widx;
   logic [WORD_W-1:0]    rf_wval;
   logic [WORD_W:0]      div_part, div_trial;
   logic                 div_bit;

   assign hilo     = {rf_ff[REG_PTR_HI], rf_ff[REG_PTR_LO]};
   assign hilo_off = hilo + MEM_AW'(rf_ff[REG_OFFSET]);
   assign pc_inc   = pc_ff + 16'd1;
   assign a_idx    = a_ff[REG_IDX_W-1:0];
   assign b_idx    = b_ff[REG_IDX_W-1:0];
   assign product  = va_ff * vb_ff;

   // Single register-file read port
   assign rd_idx = (cmd.step == ST_READ_A) ? a_idx : b_idx;
   assign rd_val = rf_ff[rd_idx];

   // One restoring divide step
   assign div_part  = {rem_ff, quo_ff[WORD_W-1]};
   assign div_trial = div_part - {1'b0, vb_ff};
   assign div_bit   = ~div_trial[WORD_W];

   // ALU
   always_comb begin
      case (op_ff)
         OP_INC:  alu_val = va_ff + 8'd1;
         OP_DEC:  alu_val = va_ff - 8'd1;
         OP_ADD:  alu_val = va_ff + vb_ff;
         OP_SUB:  alu_val = va_ff - vb_ff;
         OP_MUL:  alu_val = product[WORD_W-1:0];
         OP_AND:  alu_val = va_ff & vb_ff;
         OP_OR:   alu_val = va_ff | vb_ff;
         OP_XOR:  alu_val = va_ff ^ vb_ff;
         OP_NOT:  alu_val = ~va_ff;
         OP_SHL:  alu_val = (vb_ff >= 8'd8) ? 8'd0 : (va_ff << vb_ff[2:0]);
         OP_SHR:  alu_val = (vb_ff >= 8'd8) ? 8'd0 : (va_ff >> vb_ff[2:0]);
         default: alu_val = va_ff;
      endcase
   end

   // Step logic
   always_comb begin
      pc_in       = pc_ff;
      run_in      = run_ff;
      flags_in    = flags_ff;
      rf_in       = rf_ff;
      dsp_in      = dsp_ff;
      rtn_sp_in   = rtn_sp_ff;
      op_in       = op_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      ptr_in      = ptr_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      dest_idx_in = dest_idx_ff;
      dest_val_in = dest_val_ff;
      dest_vld_in = dest_vld_ff;
      fault_in    = fault_ff;
      res_in      = res_ff;
      code_addr   = pc_ff;
      code_we     = 1'b0;
      code_wdata  = req_data;
      data_addr   = hilo_off;
      data_we     = 1'b0;
      data_wdata  = va_ff;
      ret_addr    = rtn_sp_ff;
      ret_we      = 1'b0;
      ret_wdata   = pc_inc[7:0];
      rf_we       = 1'b0;
      rf_widx     = a_idx;
      rf_wval     = alu_val;

      unique case (cmd.step)
         ST_IDLE: begin
            if (cmd.accept) begin
               dest_idx_in = '0;
               dest_val_in = '0;
               dest_vld_in = 1'b0;
               fault_in    = 1'b0;
               code_addr   = req_address;
               data_addr   = req_address;
               data_wdata  = req_data;
               code_we     = (req_action == ACT_CODE_WR);
               data_we     = (req_action == ACT_DATA_WR);
            end
         end
         ST_FETCH_OP: code_addr = pc_ff;
         ST_FETCH_A: begin
            op_in     = code_q_ff;
            code_addr = pc_inc;
         end
         ST_FETCH_B: begin
            a_in      = code_q_ff;
            code_addr = pc_ff + 16'd2;
         end
         ST_READ_A: begin
            b_in  = code_q_ff;
            va_in = rd_val;
         end
         ST_READ_B: vb_in = rd_val;
         ST_EXEC: begin
            unique case (op_ff) inside
               OP_HALT: run_in = 1'b0;
               OP_LOAD_IMM: begin
                  rf_we   = 1'b1;
                  rf_widx = b_idx;
                  rf_wval = a_ff;
                  pc_in   = pc_ff + 16'd3;
               end
               OP_MOVE: begin
                  rf_we   = 1'b1;
                  rf_widx = b_idx;
                  rf_wval = va_ff;
                  pc_in   = pc_ff + 16'd3;
               end
               OP_LOAD, OP_STORE_PTR: pc_in = pc_ff + 16'd2;
               OP_STORE: begin
                  data_we = 1'b1;
                  pc_in   = pc_ff + 16'd2;
               end
               OP_STORE_IND: begin
                  data_addr = hilo;
                  pc_in     = pc_ff + 16'd2;
               end
               OP_PUSH: begin
                  data_addr = dsp_ff;
                  data_we   = 1'b1;
                  dsp_in    = dsp_ff + 16'd1;
                  pc_in     = pc_ff + 16'd2;
               end
               OP_POP: begin
                  dsp_in    = dsp_ff - 16'd1;
                  data_addr = dsp_ff - 16'd1;
                  pc_in     = pc_ff + 16'd2;
               end
               OP_JUMP: pc_in = hilo;
               OP_CALL: ret_we = 1'b1;
               OP_RETURN: ret_addr = rtn_sp_ff - RET_AW'(2);
               OP_INC, OP_DEC, OP_NOT: begin
                  rf_we = 1'b1;
                  pc_in = pc_ff + 16'd2;
               end
               OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
                  rf_we = 1'b1;
                  pc_in = pc_ff + 16'd3;
               end
               OP_DIV: begin
                  if (vb_ff == 8'd0) begin
                     run_in   = 1'b0;
                     fault_in = 1'b1;
                     pc_in    = pc_inc;
                  end else begin
                     quo_in = va_ff;
                     rem_in = '0;
                     cnt_in = '0;
                  end
               end
               OP_CMP: begin
                  flags_in[FLAG_EQ] = (va_ff == vb_ff);
                  if (va_ff > vb_ff) begin
                     flags_in[FLAG_GT] = 1'b1;
                  end else if (va_ff < vb_ff) begin
                     flags_in[FLAG_GT] = 1'b0;
                  end
                  pc_in = pc_ff + 16'd3;
               end
               OP_JEQ: pc_in = flags_ff[FLAG_EQ] ? hilo : pc_inc;
               OP_JNE: pc_in = flags_ff[FLAG_EQ] ? pc_inc : hilo;
               OP_JGT: pc_in = flags_ff[FLAG_GT] ? hilo : pc_inc;
               OP_JLE: pc_in = flags_ff[FLAG_GT] ? pc_inc : hilo;
               OP_CODE_LOAD: begin
                  code_addr = hilo_off;
                  pc_in     = pc_ff + 16'd2;
               end
               default: pc_in = pc_inc;
            endcase
         end
         ST_MEM_WAIT: begin
            rf_we   = 1'b1;
            rf_wval = (op_ff == OP_CODE_LOAD) ? code_q_ff : data_q_ff;
         end
         ST_PTR_LO: begin
            ptr_in[7:0] = data_q_ff;
            data_addr   = (op_ff == OP_STORE_IND) ? (hilo + 16'd1) : (hilo_off + 16'd1);
         end
         ST_PTR_HI: ptr_in[15:8] = data_q_ff;
         ST_PTR_WR: begin
            data_we   = 1'b1;
            data_addr = (op_ff == OP_STORE_IND) ? (ptr_ff + MEM_AW'(rf_ff[REG_OFFSET]))
                                                : ptr_ff;
         end
         ST_RET_LO: begin
            rf_we    = 1'b1;
            rf_widx  = REG_PTR_LO;
            rf_wval  = ret_q_ff;
            ret_addr = rtn_sp_ff - RET_AW'(1);
         end
         ST_RET_HI: begin
            if (op_ff == OP_CALL) begin
               ret_we    = 1'b1;
               ret_addr  = rtn_sp_ff + RET_AW'(1);
               ret_wdata = pc_inc[15:8];
               rtn_sp_in = rtn_sp_ff + RET_AW'(2);
               pc_in     = hilo;
            end else begin
               rf_we     = 1'b1;
               rf_widx   = REG_PTR_HI;
               rf_wval   = ret_q_ff;
               rtn_sp_in = rtn_sp_ff - RET_AW'(2);
               pc_in     = pc_inc;
            end
         end
         ST_DIV: begin
            rem_in = div_bit ? div_trial[WORD_W-1:0] : div_part[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], div_bit};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (status.div_last) begin
               rf_we   = 1'b1;
               rf_wval = {quo_ff[WORD_W-2:0], div_bit};
               pc_in   = pc_ff + 16'd3;
            end
         end
         ST_DONE: ;
      endcase

      // Register write port, tracked for the response
      if (rf_we) begin
         rf_in[rf_widx] = rf_wval;
         dest_idx_in    = rf_widx;
         dest_val_in    = rf_wval;
         dest_vld_in    = 1'b1;
      end

      if (cmd.rsp_load) begin
         res_in.program_counter = pc_ff;
         res_in.is_running      = run_ff;
         res_in.flag_bits       = flags_ff;
         res_in.dest_index      = 3'(dest_idx_ff);
         res_in.dest_value      = dest_val_ff;
         res_in.dest_valid      = dest_vld_ff;
         res_in.divide_fault    = fault_ff;
      end
   end

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= '0;
         run_ff      <= 1'b1;
         flags_ff    <= '0;
         rf_ff       <= '{default: '0};
         dsp_ff      <= '0;
         rtn_sp_ff   <= '0;
         dest_vld_ff <= 1'b0;
         fault_ff    <= 1'b0;
      end else begin
         pc_ff       <= pc_in;
         run_ff      <= run_in;
         flags_ff    <= flags_in;
         rf_ff       <= rf_in;
         dsp_ff      <= dsp_in;
         rtn_sp_ff   <= rtn_sp_in;
         dest_vld_ff <= dest_vld_in;
         fault_ff    <= fault_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      ptr_ff      <= ptr_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      dest_idx_ff <= dest_idx_in;
      dest_val_ff <= dest_val_in;
      res_ff      <= res_in;
   end

   // Code memory
   always_ff @(posedge clock) begin
      if (code_we) begin
         code_mem_ff[code_addr] <= code_wdata;
      end
      code_q_ff <= code_mem_ff[code_addr];
   end

   // Data memory
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem_ff[data_addr] <= data_wdata;
      end
      data_q_ff <= data_mem_ff[data_addr];
   end

   // Return stack memory
   always_ff @(posedge clock) begin
      if (ret_we) begin
         ret_mem_ff[ret_addr] <= ret_wdata;
      end
      ret_q_ff <= ret_mem_ff[ret_addr];
   end

   assign status.opcode       = op_ff;
   assign status.running      = run_ff;
   assign status.divisor_zero = (vb_ff == 8'd0);
   assign status.div_last     = (cnt_ff == DIV_CNT_W'(WORD_W - 1));
   assign result              = res_ff;

endmodule

FILE: rtl/core/brc_controller.sv
// ----------------------------------------------------------------------------
// brc_controller
// Sequencer: accepts requests, walks fetch/execute steps, hands off the
// response into a one-entry output register.
// ----------------------------------------------------------------------------
module brc_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  brc_pkg::action_type    req_action,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  brc_pkg::dp_status_type status,
   output brc_pkg::ctl_cmd_type   cmd
);
   import brc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.step     = state_ff;
      cmd.accept   = 1'b0;
      cmd.rsp_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_action == ACT_EXECUTE && status.running) ? ST_FETCH_OP
                                                                          : ST_DONE;
            end
         end
         ST_FETCH_OP: state_in = ST_FETCH_A;
         ST_FETCH_A:  state_in = ST_FETCH_B;
         ST_FETCH_B:  state_in = ST_READ_A;
         ST_READ_A:   state_in = ST_READ_B;
         ST_READ_B:   state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (status.opcode) inside
               OP_LOAD, OP_POP, OP_CODE_LOAD: state_in = ST_MEM_WAIT;
               OP_STORE_IND, OP_STORE_PTR:    state_in = ST_PTR_LO;
               OP_CALL:                       state_in = ST_RET_HI;
               OP_RETURN:                     state_in = ST_RET_LO;
               OP_DIV: state_in = status.divisor_zero ? ST_DONE : ST_DIV;
               default:                       state_in = ST_DONE;
            endcase
         end
         ST_MEM_WAIT: state_in = ST_DONE;
         ST_PTR_LO:   state_in = ST_PTR_HI;
         ST_PTR_HI:   state_in = ST_PTR_WR;
         ST_PTR_WR:   state_in = ST_DONE;
         ST_RET_LO:   state_in = ST_RET_HI;
         ST_RET_HI:   state_in = ST_DONE;
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the response once the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/byte_register_cpu_core.sv
// ----------------------------------------------------------------------------
// byte_register_cpu_core
// 8-bit register machine: code/data loads and single-instruction execution.
//
//   channel   dir  handshake       payload
//   req_chan  in   valid/ready     action, address, data
//   rsp_chan  out  valid/ready     pc, run, flags, dest write, divide fault
//
// Memory write requests go from idle straight to the response. Executed
// instructions take the sequential fetch of three code bytes, two reads through
// the single register-file read port and an execute step; loads, pointer stores,
// call/return and the one-bit-per-cycle divider add further steps.
// Synchronous reset clears pc, flags, registers and stack pointers; memories
// are not cleared. A new request is taken while the last response still waits.
// ----------------------------------------------------------------------------
module byte_register_cpu_core (
   input  logic       clock,
   input  logic       reset,
   brc_req_if.sink    req_chan,
   brc_rsp_if.source  rsp_chan
);
   import brc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;
   result_type    result;

   brc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   brc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_action  (req_chan.action),
      .req_address (req_chan.address),
      .req_data    (req_chan.data),
      .status      (status),
      .result      (result)
   );

   assign rsp_chan.program_counter = result.program_counter;
   assign rsp_chan.is_running      = result.is_running;
   assign rsp_chan.flag_bits       = result.flag_bits;
   assign rsp_chan.dest_index      = result.dest_index;
   assign rsp_chan.dest_value      = result.dest_value;
   assign rsp_chan.dest_valid      = result.dest_valid;
   assign rsp_chan.divide_fault    = result.divide_fault;

endmodule

FILE: rtl/core/brc_checker.sv
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_register_cpu_core_assert.svh"

module brc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       is_running,
   input logic [2:0] dest_index,
   input logic [7:0] dest_value,
   input logic       dest_valid,
   input logic       divide_fault
);

   // A divide fault always leaves the machine halted
   `BRC_ASSERT_IMPL(a_fault_halts, rsp_valid && divide_fault, !is_running)

   // No register write reports zero index and value
   `BRC_ASSERT_IMPL(a_no_dest_zero, rsp_valid && !dest_valid, dest_index == 3'd0 && dest_value == 8'd0)

   // Fault and register write never come together
   `BRC_ASSERT_IMPL(a_fault_no_write, rsp_valid && divide_fault, !dest_valid)

   // Stalled response stays up
   `BRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind byte_register_cpu_core brc_checker u_brc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .is_running   (rsp_chan.is_running),
   .dest_index   (rsp_chan.dest_index),
   .dest_value   (rsp_chan.dest_value),
   .dest_valid   (rsp_chan.dest_valid),
   .divide_fault (rsp_chan.divide_fault)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_register_cpu_core. Requests (code writes, data
// writes, executes) are queued up front together with the predicted response
// of each one; a clocked driver feeds them to the core with random gaps, and
// a clocked monitor compares every response field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import brc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1400;

   typedef struct {
      action_type  action;
      logic [15:0] address;
      logic [7:0]  data;
      bit          drain;   // marker: hold off until all responses are back
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   brc_req_if req ();
   brc_rsp_if rsp ();

   byte_register_cpu_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #5 clock = ~clock;

   // Predicted machine state
   logic [15:0] cpu_pc;
   bit          cpu_running;
   logic [1:0]  cpu_flags;
   logic [7:0]  cpu_regs [NUM_REGS];
   logic [15:0] cpu_data_sp;
   logic [7:0]  cpu_ret_sp;
   logic [7:0]  code_mem [MEM_DEPTH];
   logic [7:0]  data_mem [MEM_DEPTH];
   logic [7:0]  ret_mem  [RET_DEPTH];
   bit          code_known [MEM_DEPTH];
   bit          data_known [MEM_DEPTH];
   bit          ret_known  [RET_DEPTH];
   bit          op_seen [32];

   // Register write reported by the current step
   bit          wr_valid;
   logic [2:0]  wr_index;
   logic [7:0]  wr_value;

   request_type pending_reqs [$];
   result_type  expected_rsps [$];
   bit          allow_stop;
   int          req_count;
   int          rsp_count;
   int          errors;
   int          cycle_count;
   int          idle_cycles;

   function automatic void write_reg(logic [2:0] idx, logic [7:0] value);
      cpu_regs[idx] = value;
      wr_valid = 1'b1;
      wr_index = idx;
      wr_value = value;
   endfunction

   function automatic logic [15:0] ptr_hilo();
      return {cpu_regs[REG_PTR_HI], cpu_regs[REG_PTR_LO]};
   endfunction

   function automatic logic [15:0] ptr_offset();
      return ptr_hilo() + {8'h00, cpu_regs[REG_OFFSET]};
   endfunction

   // One request through the predictor; returns the expected response
   function automatic result_type predict_step(action_type act, logic [15:0] addr,
                                               logic [7:0] value);
      result_type  res;
      logic [15:0] p;
      logic [15:0] np;
      logic [15:0] ptr;
      logic [7:0]  op;
      logic [7:0]  va;
      logic [7:0]  vb;
      logic [2:0]  ia;
      logic [2:0]  ib;
      bit          fault;
      wr_valid = 1'b0;
      wr_index = '0;
      wr_value = '0;
      fault    = 1'b0;
      if (act == ACT_CODE_WR) begin
         code_mem[addr]   = value;
         code_known[addr] = 1'b1;
      end else if (act == ACT_DATA_WR) begin
         data_mem[addr]   = value;
         data_known[addr] = 1'b1;
      end else if (act == ACT_EXECUTE && cpu_running) begin
         p  = cpu_pc;
         op = code_mem[p];
         ia = code_mem[p + 16'd1][2:0];
         ib = code_mem[p + 16'd2][2:0];
         va = cpu_regs[ia];
         vb = cpu_regs[ib];
         np = p + 16'd3;
         op_seen[op < 8'd31 ? op : 31] = 1'b1;
         case (op)
            OP_HALT: begin
               cpu_running = 1'b0;
               np = p;
            end
            OP_LOAD_IMM: write_reg(ib, code_mem[p + 16'd1]);
            OP_MOVE:     write_reg(ib, va);
            OP_LOAD: begin
               write_reg(ia, data_mem[ptr_offset()]);
               np = p + 16'd2;
            end
            OP_STORE: begin
               ptr = ptr_offset();
               data_mem[ptr] = va;
               data_known[ptr] = 1'b1;
               np = p + 16'd2;
            end
            OP_STORE_IND: begin
               ptr = {data_mem[ptr_hilo() + 16'd1], data_mem[ptr_hilo()]};
               ptr = ptr + {8'h00, cpu_regs[REG_OFFSET]};
               data_mem[ptr] = va;
               data_known[ptr] = 1'b1;
               np = p + 16'd2;
            end
            OP_STORE_PTR: begin
               ptr = ptr_offset();
               ptr = {data_mem[ptr + 16'd1], data_mem[ptr]};
               data_mem[ptr] = va;
               data_known[ptr] = 1'b1;
               np = p + 16'd2;
            end
            OP_PUSH: begin
               data_mem[cpu_data_sp] = va;
               data_known[cpu_data_sp] = 1'b1;
               cpu_data_sp = cpu_data_sp + 16'd1;
               np = p + 16'd2;
            end
            OP_POP: begin
               cpu_data_sp = cpu_data_sp - 16'd1;
               write_reg(ia, data_mem[cpu_data_sp]);
               np = p + 16'd2;
            end
            OP_JUMP: np = ptr_hilo();
            OP_CALL: begin
               ptr = p + 16'd1;
               ret_mem[cpu_ret_sp] = ptr[7:0];
               ret_mem[cpu_ret_sp + 8'd1] = ptr[15:8];
               ret_known[cpu_ret_sp] = 1'b1;
               ret_known[cpu_ret_sp + 8'd1] = 1'b1;
               cpu_ret_sp = cpu_ret_sp + 8'd2;
               np = ptr_hilo();
            end
            OP_RETURN: begin
               write_reg(REG_PTR_LO, ret_mem[cpu_ret_sp - 8'd2]);
               write_reg(REG_PTR_HI, ret_mem[cpu_ret_sp - 8'd1]);
               cpu_ret_sp = cpu_ret_sp - 8'd2;
               np = p + 16'd1;
            end
            OP_INC: begin
               write_reg(ia, va + 8'd1);
               np = p + 16'd2;
            end
            OP_DEC: begin
               write_reg(ia, va - 8'd1);
               np = p + 16'd2;
            end
            OP_ADD: write_reg(ia, va + vb);
            OP_SUB: write_reg(ia, va - vb);
            OP_MUL: write_reg(ia, va * vb);
            OP_DIV: begin
               if (vb == 8'd0) begin
                  cpu_running = 1'b0;
                  fault = 1'b1;
                  np = p + 16'd1;
               end else begin
                  write_reg(ia, va / vb);
               end
            end
            OP_AND: write_reg(ia, va & vb);
            OP_OR:  write_reg(ia, va | vb);
            OP_XOR: write_reg(ia, va ^ vb);
            OP_NOT: begin
               write_reg(ia, ~va);
               np = p + 16'd2;
            end
            OP_SHL: write_reg(ia, (vb >= 8'd8) ? 8'd0 : 8'(va << vb));
            OP_SHR: write_reg(ia, (vb >= 8'd8) ? 8'd0 : 8'(va >> vb));
            OP_CMP: begin
               cpu_flags[FLAG_EQ] = (va == vb);
               if (va > vb) cpu_flags[FLAG_GT] = 1'b1;
               if (va < vb) cpu_flags[FLAG_GT] = 1'b0;
            end
            OP_JEQ: np = cpu_flags[FLAG_EQ] ? ptr_hilo() : p + 16'd1;
            OP_JNE: np = cpu_flags[FLAG_EQ] ? p + 16'd1 : ptr_hilo();
            OP_JGT: np = cpu_flags[FLAG_GT] ? ptr_hilo() : p + 16'd1;
            OP_JLE: np = cpu_flags[FLAG_GT] ? p + 16'd1 : ptr_hilo();
            OP_CODE_LOAD: begin
               write_reg(ia, code_mem[ptr_offset()]);
               np = p + 16'd2;
            end
            default: np = p + 16'd1;
         endcase
         cpu_pc = np;
      end
      res.program_counter = cpu_pc;
      res.is_running      = cpu_running;
      res.flag_bits       = cpu_flags;
      res.dest_index      = wr_index;
      res.dest_value      = wr_value;
      res.dest_valid      = wr_valid;
      res.divide_fault    = fault;
      return res;
   endfunction

   function automatic void queue_request(action_type act, logic [15:0] addr,
                                         logic [7:0] value);
      request_type item;
      item.action  = act;
      item.address = addr;
      item.data    = value;
      item.drain   = 1'b0;
      pending_reqs.push_back(item);
      expected_rsps.push_back(predict_step(act, addr, value));
   endfunction

   // Memory reads of an instruction must only hit entries already written
   function automatic void fill_data(logic [15:0] addr);
      if (!data_known[addr]) queue_request(ACT_DATA_WR, addr, 8'($urandom));
   endfunction

   // Place one instruction at the pc, make its operands readable, execute it
   function automatic void run_instr(opcode_type op, logic [7:0] a, logic [7:0] b);
      logic [15:0] p;
      p = cpu_pc;
      if (op == OP_RETURN && !(ret_known[cpu_ret_sp - 8'd2] && ret_known[cpu_ret_sp - 8'd1]))
         op = OP_NOP;
      if (!allow_stop && op == OP_HALT) op = OP_NOP;
      if (!allow_stop && op == OP_DIV && cpu_regs[b[2:0]] == 8'd0) op = OP_ADD;
      queue_request(ACT_CODE_WR, p, op);
      queue_request(ACT_CODE_WR, p + 16'd1, a);
      queue_request(ACT_CODE_WR, p + 16'd2, b);
      case (op)
         OP_LOAD: fill_data(ptr_offset());
         OP_STORE_IND: begin
            fill_data(ptr_hilo());
            fill_data(ptr_hilo() + 16'd1);
         end
         OP_STORE_PTR: begin
            fill_data(ptr_offset());
            fill_data(ptr_offset() + 16'd1);
         end
         OP_POP: fill_data(cpu_data_sp - 16'd1);
         OP_CODE_LOAD:
            if (!code_known[ptr_offset()])
               queue_request(ACT_CODE_WR, ptr_offset(), 8'($urandom));
         default: ;
      endcase
      queue_request(ACT_EXECUTE, 16'($urandom), 8'($urandom));
   endfunction

   function automatic opcode_type pick_opcode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)  return opcode_type'($urandom_range(255, 31));
      if (roll < 12) return OP_CALL;
      if (roll < 20) return OP_RETURN;
      if (roll < 30) return OP_LOAD_IMM;
      return opcode_type'($urandom_range(30, 1));
   endfunction

   // Register index bytes keep random upper bits; small values help shifts
   function automatic logic [7:0] pick_operand();
      return ($urandom_range(3) == 0) ? 8'($urandom_range(9)) : 8'($urandom);
   endfunction

   // Request stimulus and predictions, built before time advances
   initial begin
      request_type marker;
      int          roll;
      for (int i = 0; i < NUM_REGS; i++) cpu_regs[i] = '0;
      cpu_pc = '0;
      cpu_running = 1'b1;
      cpu_flags = '0;
      cpu_data_sp = '0;
      cpu_ret_sp = '0;
      allow_stop = 1'b0;

      // directed: address and data extremes, shifts, compares, call/return
      queue_request(ACT_DATA_WR, 16'hFFFF, 8'hFF);
      queue_request(ACT_DATA_WR, 16'h0000, 8'h00);
      queue_request(ACT_CODE_WR, 16'hFFFF, 8'h00);
      queue_request(2'd3, 16'hFFFF, 8'hFF);
      run_instr(OP_LOAD_IMM, 8'hFF, 8'd1);
      run_instr(OP_LOAD_IMM, 8'd8, 8'hFA);
      run_instr(OP_SHL, 8'd1, 8'd2);
      run_instr(OP_CMP, 8'd1, 8'd0);
      run_instr(OP_CMP, 8'd2, 8'd0);
      run_instr(OP_JLE, 8'd0, 8'd0);
      run_instr(OP_CALL, 8'd0, 8'd0);
      run_instr(OP_RETURN, 8'd0, 8'd0);

      // random: mostly instruction streams, some loose memory writes
      while (pending_reqs.size() < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 8)
            queue_request(action_type'($urandom_range(1)), 16'($urandom), 8'($urandom));
         else if (roll < 10)
            queue_request(2'd3, 16'($urandom), 8'($urandom));
         else
            run_instr(pick_opcode(), pick_operand(), pick_operand());
         if (pending_reqs.size() >= RANDOM_ITEMS / 2 && pending_reqs.size() < RANDOM_ITEMS / 2 + 6
             && !pending_reqs[pending_reqs.size() - 1].drain) begin
            marker = '{default: '0};
            marker.drain = 1'b1;
            pending_reqs.push_back(marker);
         end
      end

      // stop the machine by halt or zero divisor, then poke it while stopped
      allow_stop = 1'b1;
      if ($urandom_range(1)) begin
         run_instr(OP_HALT, 8'd0, 8'd0);
      end else begin
         run_instr(OP_LOAD_IMM, 8'd0, 8'd3);
         run_instr(OP_DIV, 8'd1, 8'd3);
      end
      for (int i = 0; i < 12; i++)
         queue_request(action_type'($urandom_range(3)), 16'($urandom), 8'($urandom));
   end

   // Reset and initial input values
   initial begin
      req.valid   = 1'b0;
      req.action  = '0;
      req.address = '0;
      req.data    = '0;
      rsp.ready   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic bit take_gap();
      // long quiet stretch with no idling at all
      if (cycle_count > 4000 && cycle_count < 9000) return 1'b0;
      return $urandom_range(99) < 22;
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_count <= 0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (req.valid && req.ready) req_count <= req_count + 1;
         if (!req.valid || req.ready) begin
            if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
               // every sent request has had its response
               req.valid <= 1'b0;
               if (!req.valid && req_count == rsp_count) void'(pending_reqs.pop_front());
            end else if (pending_reqs.size() != 0 && !take_gap()) begin
               req.valid   <= 1'b1;
               req.action  <= pending_reqs[0].action;
               req.address <= pending_reqs[0].address;
               req.data    <= pending_reqs[0].data;
               void'(pending_reqs.pop_front());
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [15:0] expected, logic [15:0] actual);
      if (expected !== actual) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expected, actual);
      end
   endtask

   // Response monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: response with no request waiting, expected none actual pc %0h",
                        $time, rsp.program_counter);
            end else begin
               want = expected_rsps.pop_front();
               check_field("program_counter", want.program_counter, rsp.program_counter);
               check_field("is_running", want.is_running, rsp.is_running);
               check_field("flag_bits", want.flag_bits, rsp.flag_bits);
               check_field("dest_index", want.dest_index, rsp.dest_index);
               check_field("dest_value", want.dest_value, rsp.dest_value);
               check_field("dest_valid", want.dest_valid, rsp.dest_valid);
               check_field("divide_fault", want.divide_fault, rsp.divide_fault);
            end
         end
         rsp.ready <= !take_gap();
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // End of run
   initial begin
      int ops;
      errors = 0;
      @(negedge reset);
      @(posedge clock);
      while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
      end
      ops = 0;
      for (int i = 0; i < 32; i++) ops += op_seen[i];
      $display("Ran %0d requests and %0d responses; %0d opcode classes executed.",
               req_count, rsp_count, ops);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
